FILE: rtl/sft_pkg.sv
// Shared constants for the symbol frequency table: request codes, sequencer
// state codes, the fixed widths of the port fields and a common resize width.
// No dependencies.
`default_nettype none

package sft_pkg;

  // Request codes carried by in_req_type
  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Sequencer state codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRCH = 3'd1;
  localparam logic [2:0] S_RDW  = 3'd2;
  localparam logic [2:0] S_RDC  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  // Fixed field widths at the ports
  localparam int unsigned IN_SYM_W   = 21;
  localparam int unsigned IN_IDX_W   = 8;
  localparam int unsigned OUT_SYM_W  = 21;
  localparam int unsigned OUT_CNT_W  = 32;
  localparam int unsigned OUT_DIST_W = 9;

  // Common width for resizing between parameterised and fixed fields
  localparam int unsigned WIDE_W = 64;

endpackage

`default_nettype wire

FILE: rtl/sft_ram.sv
// Single-port-write, single-port-read table memory with registered read
// data, holding one {symbol, count} word per table entry.
// Imports sft_pkg but uses none of its constants.
`default_nettype none

module sft_ram
  import sft_pkg::*;
#(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 53
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  wire logic [WIDTH-1:0]           wr_data,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic      [WIDTH-1:0]           rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write one word when asked
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Register the read word every cycle
  always_ff @(posedge clk) begin
    rd_data <= mem_r[rd_addr];
  end

endmodule

`default_nettype wire

FILE: rtl/symbol_frequency_table.sv
// Symbol frequency table: a sequencer that searches a first-seen-order
// table of symbols held in sft_ram, using one shared compare unit.
// Depends on sft_pkg and sft_ram.
`default_nettype none

// One request word is taken at a time; in_ready is low while it is worked
// on. An add scans the stored symbols one per cycle through the single
// read port of the table memory and the one symbol comparator, covering
// the D distinct symbols stored (at most TABLE_DEPTH); a hit ends the
// scan early. A read of a stored entry passes through S_RDW and S_RDC; a
// read past the end, a clear or an unused code goes straight to S_DONE,
// where the result word may wait on out_ready before the block is ready
// again. Every request gives
// one result word carrying the entry fields and the distinct count, total
// count and overflow flag as they stand after the request. Counts saturate
// at all ones. The table needs no clearing pass after reset or on clear:
// only entries below the distinct count are ever read.
module symbol_frequency_table
  import sft_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned SYMBOL_BITS = 21,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            in_req_type,
  input  wire logic [IN_SYM_W-1:0]   in_symbol,
  input  wire logic [IN_IDX_W-1:0]   in_entry_index,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [OUT_SYM_W-1:0]       out_entry_symbol,
  output logic [OUT_CNT_W-1:0]       out_entry_count,
  output logic                       out_entry_valid,
  output logic                       out_was_present,
  output logic [OUT_DIST_W-1:0]      out_distinct_count,
  output logic [OUT_CNT_W-1:0]       out_total_count,
  output logic                       out_overflow
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned DW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CW = (DW > IN_IDX_W) ? DW : IN_IDX_W;
  localparam int unsigned WW = SYMBOL_BITS + COUNT_BITS;

  // Sequencer and bookkeeping
  logic [2:0]             state_r, state_nxt;
  logic [SYMBOL_BITS-1:0] sym_r, sym_nxt;
  logic [DW-1:0]          ptr_r, ptr_nxt;
  logic                   cmp_vld_r, cmp_vld_nxt;
  logic [DW-1:0]          cmp_idx_r, cmp_idx_nxt;
  logic [DW-1:0]          dist_r, dist_nxt;
  logic [COUNT_BITS-1:0]  total_r, total_nxt;
  logic                   ovf_r, ovf_nxt;

  // Result being built
  logic [SYMBOL_BITS-1:0] res_sym_r, res_sym_nxt;
  logic [COUNT_BITS-1:0]  res_cnt_r, res_cnt_nxt;
  logic                   res_valid_r, res_valid_nxt;
  logic                   res_present_r, res_present_nxt;

  // Output register
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_SYM_W-1:0]   o_sym_r, o_sym_nxt;
  logic [OUT_CNT_W-1:0]   o_cnt_r, o_cnt_nxt;
  logic                   o_evalid_r, o_evalid_nxt;
  logic                   o_present_r, o_present_nxt;
  logic [OUT_DIST_W-1:0]  o_dist_r, o_dist_nxt;
  logic [OUT_CNT_W-1:0]   o_total_r, o_total_nxt;
  logic                   o_ovf_r, o_ovf_nxt;

  // Memory ports
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [WW-1:0]          wr_data;
  logic [WW-1:0]          rd_word;

  // Datapath helpers
  logic [WIDE_W-1:0]      in_sym_wide;
  logic [SYMBOL_BITS-1:0] in_sym;
  logic [SYMBOL_BITS-1:0] rd_sym;
  logic [COUNT_BITS-1:0]  rd_cnt;
  logic [COUNT_BITS-1:0]  rd_cnt_inc;
  logic [COUNT_BITS-1:0]  total_inc;
  logic                   accept;
  logic                   issue;
  logic                   hit;
  logic                   miss;
  logic                   idx_in_range;
  logic                   out_free;
  logic [WIDE_W-1:0]      res_sym_wide;
  logic [WIDE_W-1:0]      res_cnt_wide;
  logic [WIDE_W-1:0]      dist_wide;
  logic [WIDE_W-1:0]      total_wide;

  sft_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (WW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (ptr_r[AW-1:0]),
    .rd_data (rd_word)
  );

  // Resize the input symbol to the stored width
  assign in_sym_wide = WIDE_W'(in_symbol);
  assign in_sym      = in_sym_wide[SYMBOL_BITS-1:0];

  // Split the read word and form the saturating increments
  assign rd_sym     = rd_word[WW-1:COUNT_BITS];
  assign rd_cnt     = rd_word[COUNT_BITS-1:0];
  assign rd_cnt_inc = (&rd_cnt) ? rd_cnt : rd_cnt + COUNT_BITS'(1);
  assign total_inc  = (&total_r) ? total_r : total_r + COUNT_BITS'(1);

  // Handshake and search decisions
  assign in_ready     = (state_r == S_IDLE);
  assign accept       = in_valid && in_ready;
  assign out_free     = !out_valid_r || out_ready;
  assign idx_in_range = CW'(in_entry_index) < CW'(dist_r);
  assign issue        = ptr_r < dist_r;
  assign hit          = (state_r == S_SRCH) && cmp_vld_r && (rd_sym == sym_r);
  assign miss         = (state_r == S_SRCH) && !hit &&
                        ((dist_r == '0) ||
                         (cmp_vld_r && ((cmp_idx_r + DW'(1)) == dist_r)));

  // Write back on a hit, append on a miss while there is room
  assign wr_en   = hit || (miss && (dist_r != DW'(TABLE_DEPTH)));
  assign wr_addr = hit ? cmp_idx_r[AW-1:0] : dist_r[AW-1:0];
  assign wr_data = {sym_r, (hit ? rd_cnt_inc : COUNT_BITS'(1))};

  // Resize results to the port widths
  assign res_sym_wide = WIDE_W'(res_sym_r);
  assign res_cnt_wide = WIDE_W'(res_cnt_r);
  assign dist_wide    = WIDE_W'(dist_r);
  assign total_wide   = WIDE_W'(total_r);

  // Sequencer next state
  always_comb begin
    state_nxt       = state_r;
    sym_nxt         = sym_r;
    ptr_nxt         = ptr_r;
    cmp_vld_nxt     = 1'b0;
    cmp_idx_nxt     = ptr_r;
    dist_nxt        = dist_r;
    total_nxt       = total_r;
    ovf_nxt         = ovf_r;
    res_sym_nxt     = res_sym_r;
    res_cnt_nxt     = res_cnt_r;
    res_valid_nxt   = res_valid_r;
    res_present_nxt = res_present_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    o_sym_nxt       = o_sym_r;
    o_cnt_nxt       = o_cnt_r;
    o_evalid_nxt    = o_evalid_r;
    o_present_nxt   = o_present_r;
    o_dist_nxt      = o_dist_r;
    o_total_nxt     = o_total_r;
    o_ovf_nxt       = o_ovf_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_sym_nxt     = '0;
          res_cnt_nxt     = '0;
          res_valid_nxt   = 1'b0;
          res_present_nxt = 1'b0;
          case (in_req_type)
            REQ_ADD: begin
              sym_nxt   = in_sym;
              ptr_nxt   = '0;
              total_nxt = total_inc;
              state_nxt = S_SRCH;
            end
            REQ_READ: begin
              ptr_nxt   = DW'(in_entry_index);
              state_nxt = idx_in_range ? S_RDW : S_DONE;
            end
            REQ_CLEAR: begin
              dist_nxt  = '0;
              total_nxt = '0;
              ovf_nxt   = 1'b0;
              state_nxt = S_DONE;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_SRCH: begin
        // Advance the scan one entry a cycle; the compare acts on the registered read word
        if (hit) begin
          res_sym_nxt     = rd_sym;
          res_cnt_nxt     = rd_cnt_inc;
          res_valid_nxt   = 1'b1;
          res_present_nxt = 1'b1;
          state_nxt       = S_DONE;
        end else if (miss) begin
          if (dist_r != DW'(TABLE_DEPTH)) begin
            res_sym_nxt   = sym_r;
            res_cnt_nxt   = COUNT_BITS'(1);
            res_valid_nxt = 1'b1;
            dist_nxt      = dist_r + DW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          state_nxt = S_DONE;
        end else if (issue) begin
          cmp_vld_nxt = 1'b1;
          ptr_nxt     = ptr_r + DW'(1);
        end
      end
      S_RDW: begin
        // Read word lands in the memory output register
        state_nxt = S_RDC;
      end
      S_RDC: begin
        res_sym_nxt   = rd_sym;
        res_cnt_nxt   = rd_cnt;
        res_valid_nxt = 1'b1;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        // Hand the result word over once the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_sym_nxt     = res_sym_wide[OUT_SYM_W-1:0];
          o_cnt_nxt     = res_cnt_wide[OUT_CNT_W-1:0];
          o_evalid_nxt  = res_valid_r;
          o_present_nxt = res_present_r;
          o_dist_nxt    = dist_wide[OUT_DIST_W-1:0];
          o_total_nxt   = total_wide[OUT_CNT_W-1:0];
          o_ovf_nxt     = ovf_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmp_vld_r   <= 1'b0;
      dist_r      <= '0;
      total_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      dist_r      <= dist_nxt;
      total_r     <= total_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    sym_r         <= sym_nxt;
    ptr_r         <= ptr_nxt;
    cmp_idx_r     <= cmp_idx_nxt;
    res_sym_r     <= res_sym_nxt;
    res_cnt_r     <= res_cnt_nxt;
    res_valid_r   <= res_valid_nxt;
    res_present_r <= res_present_nxt;
    o_sym_r       <= o_sym_nxt;
    o_cnt_r       <= o_cnt_nxt;
    o_evalid_r    <= o_evalid_nxt;
    o_present_r   <= o_present_nxt;
    o_dist_r      <= o_dist_nxt;
    o_total_r     <= o_total_nxt;
    o_ovf_r       <= o_ovf_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_entry_symbol   = o_sym_r;
  assign out_entry_count    = o_cnt_r;
  assign out_entry_valid    = o_evalid_r;
  assign out_was_present    = o_present_r;
  assign out_distinct_count = o_dist_r;
  assign out_total_count    = o_total_r;
  assign out_overflow       = o_ovf_r;

`ifndef SYNTHESIS
  // Distinct count never exceeds the table depth
  a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dist_r <= DW'(TABLE_DEPTH))
    else $error("distinct count beyond table depth");

  // An accepted word keeps the block busy in the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("ready again straight after accept");

  // Overflow only rises while the table is full
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovf_r) |-> (dist_r == DW'(TABLE_DEPTH)))
    else $error("overflow set with room in the table");

  // A hit and a miss never coincide
  a_hit_miss: assert property (@(posedge clk) disable iff (!rst_n)
    !(hit && miss))
    else $error("search reported hit and miss together");
`endif

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// Testbench for symbol_frequency_table: random and directed add, read and clear
// words, each result checked against a table tracked alongside the block.
// Depends on sft_pkg and the symbol_frequency_table RTL.
`default_nettype none

module tb_top
  import sft_pkg::*;
();

  localparam logic [1:0]  REQ_UNUSED   = 2'd3;
  localparam int          TABLE_SLOTS  = 256;
  localparam int          HOLD_CYCLES  = 3000;
  localparam int          DRAIN_CYCLES = TABLE_SLOTS + 16;
  localparam int unsigned CYCLE_LIMIT  = 2000000;

  typedef struct packed {
    logic [OUT_SYM_W-1:0]  sym;
    logic [OUT_CNT_W-1:0]  cnt;
    logic                  valid;
    logic                  present;
    logic [OUT_DIST_W-1:0] distinct;
    logic [OUT_CNT_W-1:0]  total;
    logic                  ovf;
  } tally_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_req_type = '0;
  logic [IN_SYM_W-1:0]   in_symbol = '0;
  logic [IN_IDX_W-1:0]   in_entry_index = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [OUT_SYM_W-1:0]  out_entry_symbol;
  logic [OUT_CNT_W-1:0]  out_entry_count;
  logic                  out_entry_valid;
  logic                  out_was_present;
  logic [OUT_DIST_W-1:0] out_distinct_count;
  logic [OUT_CNT_W-1:0]  out_total_count;
  logic                  out_overflow;

  // Tracked copy of the frequency table
  logic [IN_SYM_W-1:0]  sym_tab [TABLE_SLOTS];
  logic [OUT_CNT_W-1:0] cnt_tab [TABLE_SLOTS];
  int                   n_distinct = 0;
  logic [OUT_CNT_W-1:0] total_seen = '0;
  logic                 overflow_seen = 1'b0;

  tally_t expected_tallies [$];
  int     mismatches = 0;
  int     burst_left = 1;
  int     hold_reqs = 0;

  // Result-side stall state
  int     hold_seen = 0;
  int     hold_left = 0;
  int     stall_mode = 0;
  int     mode_left = 0;
  int     slot = 0;

  symbol_frequency_table u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_symbol          (in_symbol),
    .in_entry_index     (in_entry_index),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_entry_symbol   (out_entry_symbol),
    .out_entry_count    (out_entry_count),
    .out_entry_valid    (out_entry_valid),
    .out_was_present    (out_was_present),
    .out_distinct_count (out_distinct_count),
    .out_total_count    (out_total_count),
    .out_overflow       (out_overflow)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Apply one request to the tracked table and return the word it should give
  function automatic tally_t count_request(input logic [1:0] req,
                                           input logic [IN_SYM_W-1:0] sym,
                                           input logic [IN_IDX_W-1:0] idx);
    tally_t r;
    int     pos;
    int     i;
    r = '0;
    case (req)
      REQ_ADD: begin
        pos = n_distinct;
        for (i = 0; i < n_distinct && pos == n_distinct; i++) begin
          if (sym_tab[i] == sym) pos = i;
        end
        if (total_seen != '1) total_seen = total_seen + OUT_CNT_W'(1);
        if (pos < n_distinct) begin
          if (cnt_tab[pos] != '1) cnt_tab[pos] = cnt_tab[pos] + OUT_CNT_W'(1);
          r.sym     = sym_tab[pos];
          r.cnt     = cnt_tab[pos];
          r.valid   = 1'b1;
          r.present = 1'b1;
        end else if (n_distinct < TABLE_SLOTS) begin
          sym_tab[n_distinct] = sym;
          cnt_tab[n_distinct] = OUT_CNT_W'(1);
          n_distinct++;
          r.sym   = sym;
          r.cnt   = OUT_CNT_W'(1);
          r.valid = 1'b1;
        end else begin
          overflow_seen = 1'b1;
        end
      end
      REQ_READ: begin
        if (idx < n_distinct) begin
          r.sym   = sym_tab[idx];
          r.cnt   = cnt_tab[idx];
          r.valid = 1'b1;
        end
      end
      REQ_CLEAR: begin
        n_distinct    = 0;
        total_seen    = '0;
        overflow_seen = 1'b0;
      end
      default: ;
    endcase
    r.distinct = OUT_DIST_W'(n_distinct);
    r.total    = total_seen;
    r.ovf      = overflow_seen;
    return r;
  endfunction

  // Offer one request word, hold it until taken, then idle between bursts
  task automatic send_word(input logic [1:0] req, input logic [IN_SYM_W-1:0] sym,
                           input logic [IN_IDX_W-1:0] idx);
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_symbol      <= sym;
    in_entry_index <= idx;
    do @(posedge clk); while (!in_ready);
    expected_tallies.push_back(count_request(req, sym, idx));
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200)
                                               : $urandom_range(1, 10);
    end
  endtask

  // Mostly in-range code points, some small ones, some using all 21 bits
  function automatic logic [IN_SYM_W-1:0] rand_symbol();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return IN_SYM_W'($urandom_range(0, 1114111));
      6, 7:             return IN_SYM_W'($urandom_range(0, 127));
      8:                return IN_SYM_W'($urandom_range(0, 21'h1FFFFF));
      default:          return ($urandom_range(0, 1) != 0) ? 21'h1FFFFF : 21'h0;
    endcase
  endfunction

  // Mostly a stored position, sometimes any index
  function automatic logic [IN_IDX_W-1:0] read_index();
    if (n_distinct > 0 && $urandom_range(0, 3) != 0) begin
      return IN_IDX_W'($urandom_range(0, n_distinct - 1));
    end
    return IN_IDX_W'($urandom);
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare each result word taken with the oldest expectation
  always @(posedge clk) begin : check_result
    tally_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_tallies.size() == 0) begin
        $display("%0t: result word with none expected, symbol %0h count %0h",
                 $time, out_entry_symbol, out_entry_count);
        mismatches++;
      end else begin
        want = expected_tallies.pop_front();
        check_field("entry_symbol", 32'(want.sym), 32'(out_entry_symbol));
        check_field("entry_count", want.cnt, out_entry_count);
        check_field("entry_valid", 32'(want.valid), 32'(out_entry_valid));
        check_field("was_present", 32'(want.present), 32'(out_was_present));
        check_field("distinct_count", 32'(want.distinct), 32'(out_distinct_count));
        check_field("total_count", want.total, out_total_count);
        check_field("overflow", 32'(want.ovf), 32'(out_overflow));
      end
    end
  end

  // Result side: stall modes that change now and then, plus long hold-offs on request
  always @(posedge clk) begin : result_stall
    slot = (slot + 1) % 5;
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(20, 400);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= (slot == 0);
      endcase
    end
  end

  // Reads and clears on an empty table, and the unused code
  task automatic test_empty_table();
    send_word(REQ_READ, '0, '0);
    send_word(REQ_READ, '0, 8'hFF);
    send_word(REQ_CLEAR, 21'h1FFFFF, 8'hFF);
    send_word(REQ_UNUSED, 21'h1FFFFF, 8'hFF);
  endtask

  // Symbol zero, extreme symbols, hits, reads in and past the table, clear
  task automatic test_add_and_read();
    int i;
    send_word(REQ_ADD, 21'h0, 8'h00);
    send_word(REQ_ADD, 21'h0, 8'hFF);
    send_word(REQ_ADD, 21'h1FFFFF, 8'h00);
    send_word(REQ_ADD, 21'h10FFFF, 8'h00);
    send_word(REQ_ADD, 21'h0AAAAA, 8'h55);
    send_word(REQ_ADD, 21'h155555, 8'hAA);
    send_word(REQ_ADD, 21'h1FFFFF, 8'h00);
    for (i = 0; i < 6; i++) send_word(REQ_READ, 21'h1FFFFF, IN_IDX_W'(i));
    send_word(REQ_READ, 21'h0, 8'hFF);
    send_word(REQ_UNUSED, 21'h0, 8'h00);
    send_word(REQ_CLEAR, 21'h0, 8'h00);
    send_word(REQ_READ, 21'h0, 8'h00);
    send_word(REQ_ADD, 21'h155555, 8'h00);
    send_word(REQ_READ, 21'h0, 8'h00);
  endtask

  // Fill every slot, then drop new symbols while hits still count
  task automatic test_table_full();
    logic [IN_SYM_W-1:0] filled [TABLE_SLOTS];
    int i;
    send_word(REQ_CLEAR, '0, '0);
    for (i = 0; i < TABLE_SLOTS; i++) begin
      filled[i] = {1'b0, 12'($urandom), 8'(i)};
      send_word(REQ_ADD, filled[i], IN_IDX_W'($urandom));
    end
    for (i = 0; i < 4; i++) begin
      send_word(REQ_ADD, {1'b1, 20'($urandom)}, IN_IDX_W'($urandom));
    end
    send_word(REQ_ADD, filled[TABLE_SLOTS-1], '0);
    send_word(REQ_ADD, filled[0], '0);
    send_word(REQ_READ, '0, 8'hFF);
    send_word(REQ_READ, '0, 8'h00);
    send_word(REQ_UNUSED, '0, '0);
    send_word(REQ_ADD, 21'h1FFFFF, '0);
    send_word(REQ_CLEAR, '0, '0);
    send_word(REQ_READ, '0, 8'h00);
    send_word(REQ_ADD, filled[7], '0);
  endtask

  // Hold the result side off while requests keep coming
  task automatic test_output_hold();
    int i;
    hold_reqs <= hold_reqs + 1;
    for (i = 0; i < 12; i++) begin
      if (i % 3 == 2) send_word(REQ_READ, IN_SYM_W'($urandom), read_index());
      else send_word(REQ_ADD, IN_SYM_W'($urandom_range(0, 7)), IN_IDX_W'($urandom));
    end
  endtask

  // Runs of adds over small alphabets with reads mixed in, and some noise
  task automatic test_random_traffic(input int n_items);
    logic [IN_SYM_W-1:0] alpha [64];
    int alpha_n, run_len, sent, k, pick, a_top;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 85) begin
        if ($urandom_range(0, 2) == 0) begin
          send_word(REQ_CLEAR, IN_SYM_W'($urandom), IN_IDX_W'($urandom));
          sent++;
        end
        alpha_n = ($urandom_range(0, 9) == 0) ? 64 : $urandom_range(1, 40);
        for (k = 0; k < alpha_n; k++) alpha[k] = rand_symbol();
        run_len = $urandom_range(10, 80);
        for (k = 0; k < run_len; k++) begin
          pick  = $urandom_range(0, 99);
          // skew towards a few frequent symbols half of the time
          a_top = ($urandom_range(0, 1) != 0) ? alpha_n - 1 : (alpha_n - 1) / 4;
          if (pick < 75) begin
            send_word(REQ_ADD, alpha[$urandom_range(0, a_top)], IN_IDX_W'($urandom));
          end else if (pick < 93) begin
            send_word(REQ_READ, IN_SYM_W'($urandom), read_index());
          end else if (pick < 97) begin
            send_word(REQ_ADD, rand_symbol(), IN_IDX_W'($urandom));
          end else begin
            send_word(REQ_UNUSED, IN_SYM_W'($urandom), IN_IDX_W'($urandom));
          end
        end
        sent += run_len;
      end else begin
        run_len = $urandom_range(1, 10);
        for (k = 0; k < run_len; k++) begin
          send_word(2'($urandom_range(0, 3)), IN_SYM_W'($urandom), IN_IDX_W'($urandom));
        end
        sent += run_len;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_add_and_read();
    test_table_full();
    test_random_traffic(680);
    test_output_hold();
    test_random_traffic(680);
    in_valid <= 1'b0;
    // drain outstanding results, then let the block settle
    while (expected_tallies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
